// ----- rtl/core/lbq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbq_pkg
// Shared types, widths and codes for the linked buffer queue manager.
// ----------------------------------------------------------------------------
package lbq_pkg;

  // Default number of slots in the pool
  localparam int POOL_DEPTH_DEF = 64;

  // Fixed field widths
  localparam int REQ_W       = 1;
  localparam int COMP_W      = 2;
  localparam int LINES_W     = 27;
  localparam int SLOT_W      = 6;
  localparam int STATUS_W    = 2;
  localparam int OCC_W       = 7;
  localparam int POOL_SIZE_W = 7;
  localparam int META_W      = COMP_W + LINES_W;

  // Configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 7;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_POLICY = 8'd1;

  // Reset values of the registers
  localparam logic [POOL_SIZE_W-1:0] POOL_SIZE_RST = 7'd64;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_ENQ = 1'b0;
  localparam logic [REQ_W-1:0] REQ_DEQ = 1'b1;

  // Full policy codes
  localparam logic POLICY_OVERFLOW = 1'b0;
  localparam logic POLICY_OFFLOAD  = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_OVERFLOW = 2'd2,
    STAT_OFFLOAD  = 2'd3
  } lbq_status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } lbq_state_t;

endpackage

// ----- rtl/core/linked_buffer_queue_manager_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linked_buffer_queue_manager_unit
// Buffer slot pool with a LIFO free stack and a doubly linked FIFO of filled
// slots, links held in synchronous-read memories.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive in_req_type, in_comp_id, in_line_count and
//   in_final_flush with start; the word is taken at a rising edge where start
//   is high and busy is low. An enqueue pops a free slot and links it at the
//   tail; a dequeue unlinks the head and pushes it back on the free stack.
//   Result channel: one word per command, shown for exactly one cycle with
//   out_valid high. The receiver cannot stall; it must take every word.
//   Configuration: cfg_valid/cfg_ready write channel (cfg_ready always high),
//   index 0 pool_size, index 1 full_policy. A write to either register
//   rebuilds the pool; other indexes are ignored.
// Sequence:
//   The accept edge captures the command and issues the link and metadata
//   reads; the write-back edge in ST_EXEC writes back the links and
//   registers the result, which raises the result strobe. busy is high in
//   ST_EXEC, so no new command is taken until the write-back is done.
// Reset:
//   rst_n (synchronous, active low) restores the registers and starts a
//   clearing pass that writes the link memories one slot per cycle, from
//   slot 0 up to POOL_DEPTH-1, with busy high. A rebuilding configuration
//   write starts the same pass.
// ----------------------------------------------------------------------------
module linked_buffer_queue_manager_unit #(
  parameter int POOL_DEPTH = lbq_pkg::POOL_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // command channel
  input  logic                             start,
  output logic                             busy,
  input  logic [lbq_pkg::REQ_W-1:0]        in_req_type,
  input  logic [lbq_pkg::COMP_W-1:0]       in_comp_id,
  input  logic [lbq_pkg::LINES_W-1:0]      in_line_count,
  input  logic                             in_final_flush,
  // result channel
  output logic                             out_valid,
  output logic [lbq_pkg::SLOT_W-1:0]       out_slot_index,
  output logic [lbq_pkg::COMP_W-1:0]       out_comp,
  output logic [lbq_pkg::LINES_W-1:0]      out_lines,
  output logic [lbq_pkg::STATUS_W-1:0]     out_status,
  output logic [lbq_pkg::OCC_W-1:0]        out_occupancy,
  // configuration channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lbq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lbq_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // Link width holds every slot plus the end marker; index width addresses slots
  localparam int LW = $clog2(POOL_DEPTH + 1);
  localparam int IW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam logic [LW-1:0] END_MARK = LW'(POOL_DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(POOL_DEPTH - 1);

  // Link and metadata memories
  logic [LW-1:0]              next_mem [POOL_DEPTH];
  logic [LW-1:0]              prev_mem [POOL_DEPTH];
  logic [lbq_pkg::META_W-1:0] meta_mem [POOL_DEPTH];

  // Memory ports
  logic                       nl_we, pl_we, meta_we;
  logic [IW-1:0]              nl_waddr, pl_waddr, meta_waddr;
  logic [LW-1:0]              nl_wdata, pl_wdata;
  logic [lbq_pkg::META_W-1:0] meta_wdata;
  logic [LW-1:0]              nl_rd_r, pl_rd_r;
  logic [lbq_pkg::META_W-1:0] meta_rd_r;

  // Control and pointer registers
  lbq_pkg::lbq_state_t state_r, state_nxt;
  logic [IW-1:0]       clr_idx_r, clr_idx_nxt;
  logic [LW-1:0]       head_r, head_nxt;
  logic [LW-1:0]       tail_r, tail_nxt;
  logic [LW-1:0]       free_top_r, free_top_nxt;
  logic [LW-1:0]       count_r, count_nxt;

  // Configuration registers
  logic [lbq_pkg::POOL_SIZE_W-1:0] pool_size_r;
  logic                            policy_r;

  // Captured command word
  logic [lbq_pkg::REQ_W-1:0]   req_r;
  logic [lbq_pkg::COMP_W-1:0]  comp_r;
  logic [lbq_pkg::LINES_W-1:0] lines_r;
  logic                        fin_r;

  // Result registers
  logic                          out_valid_r, out_valid_nxt;
  logic [lbq_pkg::SLOT_W-1:0]    out_slot_r, out_slot_nxt;
  logic [lbq_pkg::COMP_W-1:0]    out_comp_r, out_comp_nxt;
  logic [lbq_pkg::LINES_W-1:0]   out_lines_r, out_lines_nxt;
  lbq_pkg::lbq_status_t          out_status_r, out_status_nxt;
  logic [lbq_pkg::OCC_W-1:0]     out_occ_r, out_occ_nxt;

  logic          cfg_rebuild;
  logic          cmd_accept;
  logic [LW-1:0] used_n;
  logic [LW-1:0] clr_next_val;
  logic [LW-1:0] new_head;

  assign cfg_ready   = 1'b1;
  assign busy        = (state_r != lbq_pkg::ST_IDLE);
  assign cmd_accept  = start && !busy;
  assign cfg_rebuild = cfg_valid &&
                       ((cfg_index == lbq_pkg::CFG_POOL_SIZE) ||
                        (cfg_index == lbq_pkg::CFG_FULL_POLICY));

  // Clamp the pool size into 1..POOL_DEPTH
  always_comb begin
    if (pool_size_r == '0) begin
      used_n = LW'(1);
    end else if (32'(pool_size_r) > 32'(POOL_DEPTH)) begin
      used_n = END_MARK;
    end else begin
      used_n = LW'(pool_size_r);
    end
  end

  assign clr_next_val = LW'(clr_idx_r) + LW'(1);
  assign new_head     = (pl_rd_r < END_MARK) ? pl_rd_r : END_MARK;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_size_r <= lbq_pkg::POOL_SIZE_RST;
      policy_r    <= lbq_pkg::POLICY_OVERFLOW;
    end else if (cfg_valid && cfg_index == lbq_pkg::CFG_POOL_SIZE) begin
      pool_size_r <= cfg_data;
    end else if (cfg_valid && cfg_index == lbq_pkg::CFG_FULL_POLICY) begin
      policy_r <= cfg_data[0];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lbq_pkg::ST_CLEAR;
      clr_idx_r   <= '0;
      head_r      <= END_MARK;
      tail_r      <= END_MARK;
      free_top_r  <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      free_top_r  <= free_top_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: command capture and result word
  always_ff @(posedge clk) begin
    if (cmd_accept) begin
      req_r   <= in_req_type;
      comp_r  <= in_comp_id;
      lines_r <= in_line_count;
      fin_r   <= in_final_flush;
    end
    out_slot_r   <= out_slot_nxt;
    out_comp_r   <= out_comp_nxt;
    out_lines_r  <= out_lines_nxt;
    out_status_r <= out_status_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  // Memories: read every cycle at the addresses the next command needs
  always_ff @(posedge clk) begin
    if (nl_we) begin
      next_mem[nl_waddr] <= nl_wdata;
    end
    nl_rd_r <= next_mem[free_top_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (pl_we) begin
      prev_mem[pl_waddr] <= pl_wdata;
    end
    pl_rd_r <= prev_mem[head_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    meta_rd_r <= meta_mem[head_r[IW-1:0]];
  end

  // Sequencer: clear pass, command issue, write-back
  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    free_top_nxt   = free_top_r;
    count_nxt      = count_r;
    out_valid_nxt  = 1'b0;
    out_slot_nxt   = out_slot_r;
    out_comp_nxt   = out_comp_r;
    out_lines_nxt  = out_lines_r;
    out_status_nxt = out_status_r;
    out_occ_nxt    = out_occ_r;
    nl_we          = 1'b0;
    nl_waddr       = clr_idx_r;
    nl_wdata       = END_MARK;
    pl_we          = 1'b0;
    pl_waddr       = clr_idx_r;
    pl_wdata       = END_MARK;
    meta_we        = 1'b0;
    meta_waddr     = free_top_r[IW-1:0];
    meta_wdata     = {comp_r, lines_r};

    case (state_r)
      lbq_pkg::ST_CLEAR: begin
        // chain slot i to i+1 inside the pool, end marker beyond
        nl_we    = 1'b1;
        nl_wdata = (clr_next_val < used_n) ? clr_next_val : END_MARK;
        pl_we    = 1'b1;
        if (clr_idx_r == LAST_IDX) begin
          state_nxt = lbq_pkg::ST_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + IW'(1);
        end
      end
      lbq_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = lbq_pkg::ST_EXEC;
        end
      end
      lbq_pkg::ST_EXEC: begin
        state_nxt     = lbq_pkg::ST_IDLE;
        out_valid_nxt = 1'b1;
        out_slot_nxt  = '0;
        out_comp_nxt  = '0;
        out_lines_nxt = '0;
        if (req_r == lbq_pkg::REQ_ENQ) begin
          if (free_top_r >= END_MARK) begin
            // pool full or free stack closed
            out_status_nxt = (policy_r == lbq_pkg::POLICY_OFFLOAD) ?
                             lbq_pkg::STAT_OFFLOAD : lbq_pkg::STAT_OVERFLOW;
          end else begin
            // pop the free slot and link it behind the tail
            free_top_nxt = fin_r ? END_MARK : nl_rd_r;
            if (tail_r < END_MARK) begin
              pl_we    = 1'b1;
              pl_waddr = tail_r[IW-1:0];
              pl_wdata = free_top_r;
            end
            nl_we    = 1'b1;
            nl_waddr = free_top_r[IW-1:0];
            nl_wdata = (tail_r < END_MARK) ? tail_r : END_MARK;
            meta_we  = 1'b1;
            tail_nxt  = free_top_r;
            count_nxt = count_r + LW'(1);
            if (head_r >= END_MARK) begin
              head_nxt = free_top_r;
            end
            out_slot_nxt   = lbq_pkg::SLOT_W'(free_top_r);
            out_status_nxt = lbq_pkg::STAT_OK;
          end
        end else begin
          if (head_r >= END_MARK || count_r == '0) begin
            out_status_nxt = lbq_pkg::STAT_EMPTY;
          end else begin
            // unlink the head and push it on the free stack
            head_nxt = new_head;
            if (new_head >= END_MARK) begin
              tail_nxt = END_MARK;
            end
            nl_we    = 1'b1;
            nl_waddr = head_r[IW-1:0];
            nl_wdata = (free_top_r < END_MARK) ? free_top_r : END_MARK;
            pl_we    = 1'b1;
            pl_waddr = head_r[IW-1:0];
            pl_wdata = END_MARK;
            free_top_nxt   = head_r;
            count_nxt      = count_r - LW'(1);
            out_slot_nxt   = lbq_pkg::SLOT_W'(head_r);
            out_comp_nxt   = meta_rd_r[lbq_pkg::META_W-1:lbq_pkg::LINES_W];
            out_lines_nxt  = meta_rd_r[lbq_pkg::LINES_W-1:0];
            out_status_nxt = lbq_pkg::STAT_OK;
          end
        end
        out_occ_nxt = lbq_pkg::OCC_W'(count_nxt);
      end
      default: begin
        state_nxt = lbq_pkg::ST_CLEAR;
      end
    endcase

    // Rebuild the pool on a register write
    if (cfg_rebuild) begin
      state_nxt    = lbq_pkg::ST_CLEAR;
      clr_idx_nxt  = '0;
      head_nxt     = END_MARK;
      tail_nxt     = END_MARK;
      free_top_nxt = '0;
      count_nxt    = '0;
    end
  end

  // Drive the result ports
  assign out_valid      = out_valid_r;
  assign out_slot_index = out_slot_r;
  assign out_comp       = out_comp_r;
  assign out_lines      = out_lines_r;
  assign out_status     = out_status_r;
  assign out_occupancy  = out_occ_r;

`ifndef SYNTHESIS
  // A result word follows only a write-back cycle
  a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == lbq_pkg::ST_EXEC))
    else $error("result strobe without a preceding write-back cycle");

  // An accepted command is executed in the next cycle
  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_accept && !cfg_rebuild) |=> (state_r == lbq_pkg::ST_EXEC))
    else $error("accepted command not executed");

  // Queue occupancy never exceeds the pool
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= END_MARK)
    else $error("queue count beyond pool depth");

  // While idle, an empty queue and an end-marker head go together
  a_head_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lbq_pkg::ST_IDLE) |-> ((head_r >= END_MARK) == (count_r == '0)))
    else $error("head pointer and queue count disagree");

  // A dequeue that reports empty leaves the occupancy at zero
  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == lbq_pkg::STAT_EMPTY) |-> (out_occupancy == '0))
    else $error("empty status with queued buffers");
`endif

endmodule
